FILE: src/m4i_pkg.sv
`default_nettype none
package m4i_pkg;

    // width of one stored cofactor or determinant (signed Q32.32)
    localparam int WIDE_W = 64;
    // exact sum of six triple products fits well inside this
    localparam int ACC_W  = 128;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_COF  = 7'b0000010,
        S_CRND = 7'b0000100,
        S_DET  = 7'b0001000,
        S_DRND = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // column pick of permutation p for minor row i
    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] i);
        logic [5:0] cols;
        begin
            case (p)
                3'd0:    cols = {2'd2, 2'd1, 2'd0};
                3'd1:    cols = {2'd1, 2'd2, 2'd0};
                3'd2:    cols = {2'd2, 2'd0, 2'd1};
                3'd3:    cols = {2'd0, 2'd2, 2'd1};
                3'd4:    cols = {2'd1, 2'd0, 2'd2};
                3'd5:    cols = {2'd0, 2'd1, 2'd2};
                default: cols = 6'd0;
            endcase
            case (i)
                2'd0:    perm_col = cols[1:0];
                2'd1:    perm_col = cols[3:2];
                2'd2:    perm_col = cols[5:4];
                default: perm_col = 2'd0;
            endcase
        end
    endfunction

    // odd permutations
    function automatic logic perm_odd(input logic [2:0] p);
        begin
            case (p)
                3'd1, 3'd2, 3'd5: perm_odd = 1'b1;
                default:          perm_odd = 1'b0;
            endcase
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/m4i_div.sv
`default_nettype none
module m4i_div import m4i_pkg::*; #(
    parameter int NUM_W = 80
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [WIDE_W-1:0] i_den,
    output logic      [NUM_W-1:0]  o_quot,
    output t_div_stat              o_stat
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_quot;
    logic [WIDE_W-1:0] r_rem;
    logic [WIDE_W-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WIDE_W:0] rem2;
    logic            ge;
    logic [WIDE_W:0] diff;

    // restoring step, one quotient bit per cycle
    always_comb begin
        rem2 = {r_rem, r_quot[NUM_W-1]};
        ge   = rem2 >= {1'b0, r_den};
        diff = rem2 - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= CW'(NUM_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], ge};
            r_rem  <= ge ? diff[WIDE_W-1:0] : rem2[WIDE_W-1:0];
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

FILE: src/mat4_inverse_cofactor.sv
`default_nettype none
// channel | direction | handshake         | word
// --------+-----------+-------------------+-----------------------------------------------
// input   | in        | i_valid / o_stall | i_matrix_element (row-major, 16 per matrix)
// result  | out       | o_valid / i_stall | o_inverse_element, o_element_index,
//         |           |                   | o_singular, o_last (16 per matrix)
//
// The 16 load words are followed by the cofactors and then the determinant, computed
// on one shared 33x33 multiplier and 128-bit accumulator; each result word then comes
// from the bit-serial divider (or, if singular, is the identity) and the handshake.
// Reset (synchronous, active low) returns to loading with no word pending.
// o_stall is high from the sixteenth load word until the last result is taken;
// a stalled result word holds until taken.
module mat4_inverse_cofactor import m4i_pkg::*; #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [ELEMENT_WIDTH-1:0] i_matrix_element,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic      [ELEMENT_WIDTH-1:0] o_inverse_element,
    output logic      [3:0]               o_element_index,
    output logic                          o_singular,
    output logic                          o_last
);

    localparam int EW    = ELEMENT_WIDTH;
    localparam int NUM_W = WIDE_W + FRAC_BITS;
    localparam int OP_W  = 33;
    localparam int PR_W  = 2 * OP_W;
    localparam logic [WIDE_W-1:0] MAXPOS  = (WIDE_W'(1) << (EW - 1)) - 1'b1;
    localparam logic [WIDE_W-1:0] ONE_RAW = WIDE_W'(1) << FRAC_BITS;
    localparam logic [WIDE_W-1:0] ONE_SAT = (ONE_RAW > MAXPOS) ? MAXPOS : ONE_RAW;
    localparam logic [ACC_W-1:0]  HALF    = ACC_W'(1) << (FRAC_BITS - 1);

    t_state                   r_state;
    logic [3:0]               r_cnt;
    logic [3:0]               r_k;
    logic [2:0]               r_p;
    logic [2:0]               r_ph;
    logic [EW-1:0]            r_src [16];
    logic [WIDE_W-1:0]        r_cof [16];
    logic [WIDE_W-1:0]        r_det;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [OP_W-1:0]   r_opa;
    logic signed [OP_W-1:0]   r_opd;
    logic [WIDE_W-1:0]        r_t;
    logic signed [PR_W-1:0]   r_prod;
    logic                     r_sing;
    logic                     r_neg;
    logic [EW-1:0]            r_out;
    logic                     r_out_valid;
    logic                     r_div_start;

    // operand fetch addresses
    logic [1:0]        row_i, row, colsel, col;
    logic [3:0]        src_addr, cof_addr;
    logic [EW-1:0]     src_rd;
    logic [WIDE_W-1:0] cof_rd;

    always_comb begin
        row_i  = r_ph[1:0];
        row    = (row_i >= r_k[1:0]) ? 2'(row_i + 1'b1) : row_i;
        colsel = perm_col(r_p, row_i);
        col    = (colsel >= r_k[3:2]) ? 2'(colsel + 1'b1) : colsel;
        src_addr = (r_state == S_DET) ? {2'b00, r_k[1:0]} : {row, col};
        cof_addr = (r_state == S_DET) ? {r_k[1:0], 2'b00} : r_k;
        src_rd = r_src[src_addr];
        cof_rd = r_cof[cof_addr];
    end

    function automatic logic signed [OP_W-1:0] sx(input logic [EW-1:0] x);
        sx = {{(OP_W - EW){x[EW-1]}}, x};
    endfunction

    // shared multiplier
    logic signed [OP_W-1:0] op_a, op_b;
    logic signed [PR_W-1:0] mul;

    always_comb begin
        op_a = r_opa;
        op_b = sx(src_rd);
        if (r_state == S_COF) begin
            case (r_ph)
                3'd3: begin
                    op_a = {1'b0, r_t[31:0]};
                    op_b = r_opd;
                end
                3'd4: begin
                    op_a = {r_t[63], r_t[63:32]};
                    op_b = r_opd;
                end
                default: begin
                    op_a = r_opa;
                    op_b = sx(src_rd);
                end
            endcase
        end else if (r_state == S_DET) begin
            if (r_ph == 3'd1) begin
                op_b = {1'b0, cof_rd[31:0]};
            end else begin
                op_b = {cof_rd[63], cof_rd[63:32]};
            end
        end
        mul = op_a * op_b;
    end

    // accumulator term: low partial or high partial shifted up a word
    logic                    hi_part, term_neg;
    logic signed [ACC_W-1:0] term, acc_next;

    always_comb begin
        hi_part  = (r_state == S_COF) ? (r_ph == 3'd5) : (r_ph == 3'd3);
        term_neg = (r_state == S_COF) && (perm_odd(r_p) ^ r_k[2] ^ r_k[0]);
        if (hi_part) begin
            term = {{(ACC_W - PR_W - 32){r_prod[PR_W-1]}}, r_prod, 32'b0};
        end else begin
            term = {{(ACC_W - PR_W){r_prod[PR_W-1]}}, r_prod};
        end
        acc_next = term_neg ? r_acc - term : r_acc + term;
    end

    // round half up by FRAC_BITS, saturate to 64 bits
    logic signed [ACC_W-1:0] shifted;
    logic [WIDE_W-1:0]       rnd;
    logic                    fits;

    always_comb begin
        shifted = (r_acc + $signed(HALF)) >>> FRAC_BITS;
        fits    = (&shifted[ACC_W-1:WIDE_W-1]) | ~(|shifted[ACC_W-1:WIDE_W-1]);
        if (fits) begin
            rnd = shifted[WIDE_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            rnd = {1'b1, {(WIDE_W - 1){1'b0}}};
        end else begin
            rnd = {1'b0, {(WIDE_W - 1){1'b1}}};
        end
    end

    // divider
    logic [WIDE_W-1:0] cof_mag, det_mag;
    logic [NUM_W-1:0]  div_num, div_quot;
    t_div_stat         div_stat;

    always_comb begin
        cof_mag = cof_rd[WIDE_W-1] ? WIDE_W'(-cof_rd) : cof_rd;
        det_mag = r_det[WIDE_W-1] ? WIDE_W'(-r_det) : r_det;
        div_num = {cof_mag, {FRAC_BITS{1'b0}}};
    end

    m4i_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (div_num),
        .i_den   (det_mag),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    // quotient saturation
    logic [EW-1:0] q_sat;

    always_comb begin
        if (r_neg) begin
            if (div_quot > NUM_W'(MAXPOS) + 1'b1) begin
                q_sat = {1'b1, {(EW - 1){1'b0}}};
            end else begin
                q_sat = EW'(-div_quot[EW-1:0]);
            end
        end else if (div_quot > NUM_W'(MAXPOS)) begin
            q_sat = MAXPOS[EW-1:0];
        end else begin
            q_sat = div_quot[EW-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_k         <= '0;
            r_p         <= '0;
            r_ph        <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        r_src[r_cnt] <= i_matrix_element;
                        r_cnt        <= r_cnt + 1'b1;
                        if (r_cnt == 4'd15) begin
                            r_state <= S_COF;
                            r_k     <= '0;
                            r_p     <= '0;
                            r_ph    <= '0;
                            r_acc   <= '0;
                        end
                    end
                end
                S_COF: begin
                    r_ph <= (r_ph >= 3'd5) ? 3'd0 : r_ph + 1'b1;
                    case (r_ph)
                        3'd0: r_opa <= sx(src_rd);
                        3'd1: r_prod <= mul;
                        3'd2: begin
                            r_opd <= sx(src_rd);
                            r_t   <= r_prod[WIDE_W-1:0];
                        end
                        3'd3: r_prod <= mul;
                        3'd4: begin
                            r_acc  <= acc_next;
                            r_prod <= mul;
                        end
                        3'd5: begin
                            r_acc <= acc_next;
                            if (r_p == 3'd5) begin
                                r_state <= S_CRND;
                            end else begin
                                r_p <= r_p + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_CRND: begin
                    r_cof[r_k] <= rnd;
                    r_acc      <= '0;
                    r_p        <= '0;
                    r_ph       <= '0;
                    r_k        <= r_k + 1'b1;
                    r_state    <= (r_k == 4'd15) ? S_DET : S_COF;
                end
                S_DET: begin
                    r_ph <= (r_ph >= 3'd3) ? 3'd0 : r_ph + 1'b1;
                    case (r_ph)
                        3'd0: r_opa <= sx(src_rd);
                        3'd1: r_prod <= mul;
                        3'd2: begin
                            r_acc  <= acc_next;
                            r_prod <= mul;
                        end
                        3'd3: begin
                            r_acc <= acc_next;
                            if (r_k[1:0] == 2'd3) begin
                                r_state <= S_DRND;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DRND: begin
                    r_det   <= rnd;
                    r_sing  <= (rnd == '0);
                    r_k     <= '0;
                    r_ph    <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_ph == 3'd0) begin
                        r_neg <= cof_rd[WIDE_W-1] ^ r_det[WIDE_W-1];
                        if (r_sing) begin
                            r_out       <= (r_k[3:2] == r_k[1:0]) ? ONE_SAT[EW-1:0] : '0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_div_start <= 1'b1;
                            r_ph        <= 3'd1;
                        end
                    end else begin
                        r_div_start <= 1'b0;
                        if (div_stat.done && !div_stat.busy) begin
                            r_out       <= q_sat;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        r_ph        <= '0;
                        r_k         <= r_k + 1'b1;
                        r_state     <= (r_k == 4'd15) ? S_LOAD : S_DIV;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_stall           = (r_state != S_LOAD);
    assign o_valid           = r_out_valid;
    assign o_inverse_element = r_out;
    assign o_element_index   = r_k;
    assign o_singular        = r_sing;
    assign o_last            = (r_k == 4'd15);

endmodule
`default_nettype wire
